@@ sv/pfct_pkg.sv @@
`default_nettype none

package pfct_pkg;

  // price and bound widths
  localparam int PRICE_W = 31;
  localparam int BOUND_W = PRICE_W + 1;
  localparam int REV_W   = 7;
  localparam int SPAN_W  = PRICE_W + REV_W;
  localparam int CMP_W   = SPAN_W + 2;
  localparam int CNT_W   = $clog2(PRICE_W);

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * PRICE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * BOUND_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSAL = 1'd1;

  localparam logic [REV_W-1:0] REV_RESET = 7'd3;

  // series phase codes
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

endpackage

`default_nettype wire

@@ sv/point_figure_column_tracker_unit.sv @@
// Flow: a bar is accepted, then the shared radix-2 remainder unit divides the high and
// then the low by the box size, then the bounds are extended and checked for a reversal.
// A new bar is taken only when the unit is back in idle with the last one. A first bar
// that ends its series is dropped at acceptance, with no division. An emit waits while
// the last beat is still waiting in the output register.
// Reset: rst_n is synchronous, active low; it clears the series state, the sequencer
// and the output valid flag, and sets box_size to 1 and reversal_boxes to 3.
`default_nettype none

module point_figure_column_tracker_unit
  import pfct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,    // bar_high, bar_low
  input  wire logic                   in_tlast,    // series_end

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // column_top, column_bottom
  output logic [OUT_TUSER_W-1:0]      out_tuser,   // column_rising
  output logic                        out_tlast,   // run_last

  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [PRICE_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIVH     = 3'd1;
  localparam logic [2:0] S_DIVL     = 3'd2;
  localparam logic [2:0] S_EXT      = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_EMIT_REV = 3'd5;
  localparam logic [2:0] S_EMIT_END = 3'd6;

  logic [2:0]         state_r;
  logic [1:0]         phase_r;
  logic [PRICE_W-1:0] first_high_r;
  logic               rising_r;
  logic [BOUND_W-1:0] top_r;
  logic [BOUND_W-1:0] bottom_r;

  logic [PRICE_W-1:0] box_r;
  logic [REV_W-1:0]   rev_r;

  logic [PRICE_W-1:0] hi_r;
  logic [PRICE_W-1:0] lo_r;
  logic               end_r;
  logic [PRICE_W-1:0] b_r;
  logic [SPAN_W-1:0]  span_r;

  logic [PRICE_W-1:0] div_sh_r;
  logic [PRICE_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PRICE_W-1:0] rh_r;
  logic [PRICE_W-1:0] rl_r;

  logic               out_tvalid_r;
  logic               out_rising_r;
  logic [BOUND_W-1:0] out_top_r;
  logic [BOUND_W-1:0] out_bottom_r;
  logic               out_last_r;

  logic [PRICE_W-1:0] in_hi;
  logic [PRICE_W-1:0] in_lo;
  logic [PRICE_W-1:0] b_eff;
  logic               in_acc;
  logic [BOUND_W-1:0] trial;
  logic               trial_ge;
  logic [PRICE_W-1:0] rem_nxt;
  logic [BOUND_W-1:0] qtop_hi;
  logic [BOUND_W-1:0] qbot_lo;
  logic               rise_eff;
  logic               x_hit;
  logic               o_hit;
  logic               slot_free;
  logic               out_load;

  assign in_hi  = in_tdata[PRICE_W-1:0];
  assign in_lo  = in_tdata[2*PRICE_W-1:PRICE_W];
  assign b_eff  = (box_r == '0) ? PRICE_W'(1) : box_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // one restoring step of the remainder unit: bring in the next dividend bit
  assign trial    = {rem_r, div_sh_r[PRICE_W-1]};
  assign trial_ge = (trial >= {1'b0, b_r});
  assign rem_nxt  = trial_ge ? PRICE_W'(trial - {1'b0, b_r}) : trial[PRICE_W-1:0];

  // requantized bounds from the remainders
  assign qtop_hi = BOUND_W'(hi_r) - BOUND_W'(rh_r) + BOUND_W'(b_r);
  assign qbot_lo = BOUND_W'(lo_r - rl_r);

  assign rise_eff = (phase_r == PH_FIRST) ? (hi_r > first_high_r) : rising_r;

  // reversal tests, wide enough that nothing wraps
  assign x_hit = (CMP_W'(lo_r) + CMP_W'(span_r)) < CMP_W'(top_r);
  assign o_hit = CMP_W'(hi_r) > (CMP_W'(bottom_r) + CMP_W'(span_r));

  assign slot_free = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_EMIT_REV || state_r == S_EMIT_END) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= PRICE_W'(1);
      rev_r <= REV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_SIZE: box_r <= cfg_wdata;
        REG_REVERSAL: rev_r <= cfg_wdata[REV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_NONE;
      first_high_r <= '0;
      rising_r     <= 1'b0;
      top_r        <= '0;
      bottom_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            hi_r     <= in_hi;
            lo_r     <= in_lo;
            end_r    <= in_tlast;
            b_r      <= b_eff;
            span_r   <= {{REV_W{1'b0}}, b_eff} * {{PRICE_W{1'b0}}, rev_r};
            div_sh_r <= in_hi;
            rem_r    <= '0;
            cnt_r    <= CNT_W'(PRICE_W - 1);
            // a lone bar that ends its series leaves nothing behind
            if (phase_r == PH_NONE && in_tlast) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DIVH;
            end
          end
        end
        S_DIVH: begin
          rem_r    <= rem_nxt;
          div_sh_r <= div_sh_r << 1;
          cnt_r    <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            rh_r     <= rem_nxt;
            div_sh_r <= lo_r;
            rem_r    <= '0;
            cnt_r    <= CNT_W'(PRICE_W - 1);
            state_r  <= S_DIVL;
          end
        end
        S_DIVL: begin
          rem_r    <= rem_nxt;
          div_sh_r <= div_sh_r << 1;
          cnt_r    <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            rl_r    <= rem_nxt;
            state_r <= S_EXT;
          end
        end
        S_EXT: begin
          if (phase_r == PH_NONE) begin
            first_high_r <= hi_r;
            top_r        <= qtop_hi;
            bottom_r     <= qbot_lo;
            phase_r      <= PH_FIRST;
            state_r      <= S_IDLE;
          end else begin
            rising_r <= rise_eff;
            phase_r  <= PH_RUN;
            if (rise_eff && (BOUND_W'(hi_r) > top_r)) begin
              top_r <= qtop_hi;
            end
            if (!rise_eff && (BOUND_W'(lo_r) < bottom_r)) begin
              bottom_r <= qbot_lo;
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rising_r ? x_hit : o_hit) begin
            state_r <= S_EMIT_REV;
          end else if (end_r) begin
            state_r <= S_EMIT_END;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT_REV: begin
          if (slot_free) begin
            out_rising_r <= rising_r;
            out_top_r    <= top_r;
            out_bottom_r <= bottom_r;
            out_last_r   <= !end_r;
            if (rising_r) begin
              top_r    <= top_r - BOUND_W'(b_r);
              bottom_r <= qbot_lo;
              rising_r <= 1'b0;
            end else begin
              bottom_r <= bottom_r + BOUND_W'(b_r);
              top_r    <= qtop_hi;
              rising_r <= 1'b1;
            end
            state_r <= end_r ? S_EMIT_END : S_IDLE;
          end
        end
        S_EMIT_END: begin
          if (slot_free) begin
            out_rising_r <= rising_r;
            out_top_r    <= top_r;
            out_bottom_r <= bottom_r;
            out_last_r   <= 1'b1;
            phase_r      <= PH_NONE;
            first_high_r <= '0;
            rising_r     <= 1'b0;
            top_r        <= '0;
            bottom_r     <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_bottom_r, out_top_r});
  assign out_tuser  = OUT_TUSER_W'(out_rising_r);
  assign out_tlast  = out_last_r;

  // partial remainder stays below the divisor throughout a division
  a_rem_below_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVH || state_r == S_DIVL) |-> (rem_r < b_r))
    else $error("remainder not below box size");

  // a reversal beat that is not last is always followed by the closing beat
  a_rev_then_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_last_r) |-> (state_r == S_EMIT_END))
    else $error("non-last beat without pending closing column");

  // a new beat only comes out of an emit state
  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_EMIT_REV || $past(state_r) == S_EMIT_END))
    else $error("output beat raised outside emit");

  // reversal flips the column direction
  a_rev_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_REV && slot_free) |=> (rising_r != $past(rising_r)))
    else $error("reversal did not flip direction");

  // input is only taken with the remainder unit at rest
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVH || state_r == S_DIVL) |=> $stable(hi_r) && $stable(b_r))
    else $error("bar registers changed during division");

endmodule

`default_nettype wire
